@@ rtl/kts_pkg.sv @@
// Package for the Kahn topological sort block: sizes, item types and helpers.
`timescale 1ns / 1ps

package kts_pkg;

    // Graph capacity
    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 256;

    // Field and counter widths
    localparam int NODE_W     = 6;                        // vertex field width
    localparam int CFG_W      = 7;                        // node_count register width
    localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);    // counts 0..MAX_NODES
    localparam int EDGE_AW    = $clog2(MAX_EDGES);        // edge store address
    localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);    // counts 0..MAX_EDGES
    localparam int DEG_W      = EDGE_CNT_W;               // in-degree can reach MAX_EDGES
    localparam int EDGE_W     = 2 * NODE_W;               // stored {source, target}

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(64);

    // One input item
    typedef struct packed {
        logic [NODE_W-1:0] edge_source;
        logic [NODE_W-1:0] edge_target;
        logic              carries_edge;
        logic              final_item;
    } edge_item_t;

    // One result item
    typedef struct packed {
        logic [NODE_W-1:0] vertex;
        logic              vertex_valid;
        logic              last_of_run;
        logic              cycle_found;
        logic              edges_dropped;
    } order_item_t;

    // Pack an edge for the edge store
    function automatic logic [EDGE_W-1:0] pack_edge(input logic [NODE_W-1:0] src,
                                                    input logic [NODE_W-1:0] dst);
        pack_edge = {src, dst};
    endfunction

endpackage

@@ rtl/kahn_topological_sort_top.sv @@
// Kahn topological sort engine: edge loader, in-degree scan and edge walk sequencer.
//
//   channel  direction  handshake                   payload
//   edge     input      edge_valid / edge_stall     edge_item  (edge_item_t)
//   order    output     order_valid / order_stall   order_item (order_item_t)
//   cfg      input      cfg_valid / cfg_ready       cfg_data   (node_count)
//
// A non-final item with a kept edge passes through ST_LOAD_WR for a read-modify-write
// of the in-degree memory port; a dropped or absent edge leaves the sequencer idle.
// The sort then scans all in-degrees, and for every vertex walks the whole edge store
// and updates the in-degree of each edge that leaves it; the single edge store read
// port serialises this walk.
// Reset clears control state and the in-degree valid bits and sets node_count
// to 64; no clearing pass is needed. edge_stall is high whenever the sequencer is
// not idle. A stalled output holds the sequencer until the result is taken.
`timescale 1ns / 1ps

module kahn_topological_sort_top
    import kts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Edge items
    input  logic              edge_valid,
    output logic              edge_stall,
    input  edge_item_t        edge_item,
    // Order items
    output logic              order_valid,
    input  logic              order_stall,
    output order_item_t       order_item,
    // node_count register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_LOAD_WR  = 11'b000_0000_0010,
        ST_SCAN_RD  = 11'b000_0000_0100,
        ST_SCAN_CHK = 11'b000_0000_1000,
        ST_POP      = 11'b000_0001_0000,
        ST_POP_WAIT = 11'b000_0010_0000,
        ST_WALK_RD  = 11'b000_0100_0000,
        ST_WALK_CHK = 11'b000_1000_0000,
        ST_DEG_UPD  = 11'b001_0000_0000,
        ST_EMIT     = 11'b010_0000_0000,
        ST_NONE     = 11'b100_0000_0000
    } sort_state_t;

    sort_state_t            state_reg, state_next;
    logic [CFG_W-1:0]       node_count_reg;
    logic [EDGE_CNT_W-1:0]  edge_total_reg, edge_total_next;
    logic                   drop_reg, drop_next;
    logic [MAX_NODES-1:0]   deg_valid_reg, deg_valid_next;
    logic                   deg_vld_q_reg, deg_vld_q_next;
    logic [NODE_CNT_W-1:0]  head_reg, head_next;
    logic [NODE_CNT_W-1:0]  tail_reg, tail_next;
    logic [NODE_CNT_W-1:0]  emitted_reg, emitted_next;
    logic [NODE_CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [EDGE_CNT_W-1:0]  edge_idx_reg, edge_idx_next;
    logic [NODE_W-1:0]      cur_v_reg, cur_v_next;
    logic [NODE_W-1:0]      tgt_reg, tgt_next;
    logic                   final_reg, final_next;
    logic                   out_valid_reg, out_valid_next;
    order_item_t            out_item_reg, out_item_next;

    // Memory ports
    logic                   edge_wr_en;
    logic [EDGE_AW-1:0]     edge_wr_addr;
    logic [EDGE_W-1:0]      edge_wr_data;
    logic                   edge_rd_en;
    logic [EDGE_AW-1:0]     edge_rd_addr;
    logic [EDGE_W-1:0]      edge_rd_data;
    logic                   deg_wr_en;
    logic [NODE_W-1:0]      deg_wr_addr;
    logic [DEG_W-1:0]       deg_wr_data;
    logic                   deg_rd_en;
    logic [NODE_W-1:0]      deg_rd_addr;
    logic [DEG_W-1:0]       deg_rd_data;
    logic                   fifo_wr_en;
    logic [NODE_W-1:0]      fifo_wr_addr;
    logic [NODE_W-1:0]      fifo_rd_data;
    logic                   fifo_rd_en;

    logic [NODE_CNT_W-1:0]  n_eff;
    logic                   in_accept;
    logic                   edge_ok;
    logic [DEG_W-1:0]       deg_cur;
    logic                   out_free;
    logic                   queue_empty;
    logic [NODE_CNT_W-1:0]  emitted_inc;
    logic [NODE_W-1:0]      walk_src;
    logic [NODE_W-1:0]      walk_tgt;

    // Effective vertex count, clamped to capacity
    assign n_eff = (node_count_reg > CFG_W'(MAX_NODES)) ? NODE_CNT_W'(MAX_NODES)
                                                        : NODE_CNT_W'(node_count_reg);

    assign edge_stall  = (state_reg != ST_IDLE);
    assign in_accept   = edge_valid && !edge_stall;
    assign cfg_ready   = 1'b1;
    assign order_valid = out_valid_reg;
    assign order_item  = out_item_reg;

    // Keep an edge only if both endpoints are in range and the store has room
    assign edge_ok = edge_item.carries_edge
                  && (NODE_CNT_W'(edge_item.edge_source) < n_eff)
                  && (NODE_CNT_W'(edge_item.edge_target) < n_eff)
                  && (edge_total_reg < EDGE_CNT_W'(MAX_EDGES));

    assign deg_cur     = deg_vld_q_reg ? deg_rd_data : '0;
    assign out_free    = !out_valid_reg || !order_stall;
    assign queue_empty = (head_reg == tail_reg);
    assign emitted_inc = emitted_reg + 1'b1;
    assign walk_src    = edge_rd_data[EDGE_W-1:NODE_W];
    assign walk_tgt    = edge_rd_data[NODE_W-1:0];

    // Edge store
    kts_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .wr_addr (edge_wr_addr),
        .wr_data (edge_wr_data),
        .rd_en   (edge_rd_en),
        .rd_addr (edge_rd_addr),
        .rd_data (edge_rd_data)
    );

    // In-degree counts; entries without a valid bit read as zero
    kts_ram #(
        .WIDTH (DEG_W),
        .DEPTH (MAX_NODES)
    ) u_deg_ram (
        .clk     (clk),
        .wr_en   (deg_wr_en),
        .wr_addr (deg_wr_addr),
        .wr_data (deg_wr_data),
        .rd_en   (deg_rd_en),
        .rd_addr (deg_rd_addr),
        .rd_data (deg_rd_data)
    );

    // Ready queue
    kts_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (fifo_wr_en),
        .wr_addr (fifo_wr_addr),
        .wr_data (fifo_wr_en && (state_reg == ST_SCAN_CHK) ? scan_idx_reg[NODE_W-1:0]
                                                            : tgt_reg),
        .rd_en   (fifo_rd_en),
        .rd_addr (head_reg[NODE_W-1:0]),
        .rd_data (fifo_rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        edge_total_next = edge_total_reg;
        drop_next      = drop_reg;
        deg_valid_next = deg_valid_reg;
        deg_vld_q_next = deg_vld_q_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        emitted_next   = emitted_reg;
        scan_idx_next  = scan_idx_reg;
        edge_idx_next  = edge_idx_reg;
        cur_v_next     = cur_v_reg;
        tgt_next       = tgt_reg;
        final_next     = final_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && order_stall;

        edge_wr_en   = 1'b0;
        edge_wr_addr = edge_total_reg[EDGE_AW-1:0];
        edge_wr_data = pack_edge(edge_item.edge_source, edge_item.edge_target);
        edge_rd_en   = 1'b0;
        edge_rd_addr = edge_idx_reg[EDGE_AW-1:0];
        deg_wr_en    = 1'b0;
        deg_wr_addr  = tgt_reg;
        deg_wr_data  = deg_cur + 1'b1;
        deg_rd_en    = 1'b0;
        deg_rd_addr  = edge_item.edge_target;
        fifo_wr_en   = 1'b0;
        fifo_wr_addr = tail_reg[NODE_W-1:0];
        fifo_rd_en   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    tgt_next   = edge_item.edge_target;
                    final_next = edge_item.final_item;
                    if (edge_ok)
                    begin
                        // Store the edge and fetch its target's in-degree
                        edge_wr_en      = 1'b1;
                        edge_total_next = edge_total_reg + 1'b1;
                        deg_rd_en       = 1'b1;
                        deg_vld_q_next  = deg_valid_reg[edge_item.edge_target];
                        state_next      = ST_LOAD_WR;
                    end
                    else
                    begin
                        if (edge_item.carries_edge)
                        begin
                            drop_next = 1'b1;
                        end
                        if (edge_item.final_item)
                        begin
                            scan_idx_next = '0;
                            state_next    = ST_SCAN_RD;
                        end
                    end
                end
            end

            ST_LOAD_WR:
            begin
                // Bump the target's in-degree
                deg_wr_en               = 1'b1;
                deg_wr_data             = deg_cur + 1'b1;
                deg_valid_next[tgt_reg] = 1'b1;
                if (final_reg)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN_RD:
            begin
                if (scan_idx_reg == n_eff)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    deg_rd_en      = 1'b1;
                    deg_rd_addr    = scan_idx_reg[NODE_W-1:0];
                    deg_vld_q_next = deg_valid_reg[scan_idx_reg[NODE_W-1:0]];
                    state_next     = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                // Queue vertices with no incoming edge, in index order
                if (deg_cur == '0)
                begin
                    fifo_wr_en = 1'b1;
                    tail_next  = tail_reg + 1'b1;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                state_next    = ST_SCAN_RD;
            end

            ST_POP:
            begin
                if (queue_empty)
                begin
                    state_next = ST_NONE;
                end
                else
                begin
                    fifo_rd_en = 1'b1;
                    head_next  = head_reg + 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT:
            begin
                cur_v_next    = fifo_rd_data;
                edge_idx_next = '0;
                state_next    = ST_WALK_RD;
            end

            ST_WALK_RD:
            begin
                if (edge_idx_reg == edge_total_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    edge_rd_en    = 1'b1;
                    edge_idx_next = edge_idx_reg + 1'b1;
                    state_next    = ST_WALK_CHK;
                end
            end

            ST_WALK_CHK:
            begin
                // Follow edges that leave the current vertex
                if (walk_src == cur_v_reg)
                begin
                    tgt_next       = walk_tgt;
                    deg_rd_en      = 1'b1;
                    deg_rd_addr    = walk_tgt;
                    deg_vld_q_next = deg_valid_reg[walk_tgt];
                    state_next     = ST_DEG_UPD;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end

            ST_DEG_UPD:
            begin
                // Drop the target's in-degree; queue it when it reaches zero
                if (deg_cur != '0)
                begin
                    deg_wr_en   = 1'b1;
                    deg_wr_data = deg_cur - 1'b1;
                    if (deg_cur == DEG_W'(1))
                    begin
                        fifo_wr_en = 1'b1;
                        tail_next  = tail_reg + 1'b1;
                    end
                end
                state_next = ST_WALK_RD;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.vertex        = cur_v_reg;
                    out_item_next.vertex_valid  = 1'b1;
                    out_item_next.last_of_run   = queue_empty;
                    out_item_next.cycle_found   = queue_empty && (emitted_inc < n_eff);
                    out_item_next.edges_dropped = queue_empty && drop_reg;
                    emitted_next                = emitted_inc;
                    state_next                  = ST_POP;
                    if (queue_empty)
                    begin
                        edge_total_next = '0;
                        drop_next       = 1'b0;
                        deg_valid_next  = '0;
                        head_next       = '0;
                        tail_next       = '0;
                        emitted_next    = '0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            ST_NONE:
            begin
                // Nothing could be ordered: report one invalid item
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.vertex        = '0;
                    out_item_next.vertex_valid  = 1'b0;
                    out_item_next.last_of_run   = 1'b1;
                    out_item_next.cycle_found   = (n_eff != '0);
                    out_item_next.edges_dropped = drop_reg;
                    edge_total_next             = '0;
                    drop_next                   = 1'b0;
                    deg_valid_next              = '0;
                    head_next                   = '0;
                    tail_next                   = '0;
                    emitted_next                = '0;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            edge_total_reg <= '0;
            drop_reg       <= 1'b0;
            deg_valid_reg  <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            emitted_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            drop_reg       <= drop_next;
            deg_valid_reg  <= deg_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            emitted_reg    <= emitted_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        deg_vld_q_reg <= deg_vld_q_next;
        scan_idx_reg  <= scan_idx_next;
        edge_idx_reg  <= edge_idx_next;
        cur_v_reg     <= cur_v_next;
        tgt_reg       <= tgt_next;
        final_reg     <= final_next;
        out_item_reg  <= out_item_next;
    end

    // Queue pointers stay ordered and within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= tail_reg) && (tail_reg <= NODE_CNT_W'(MAX_NODES)))
        else $error("ready queue pointers out of order");

    // Edge count never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= EDGE_CNT_W'(MAX_EDGES))
        else $error("edge count beyond store size");

    // The idle sequencer holds an empty queue and no emitted count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (head_reg == '0) && (tail_reg == '0) && (emitted_reg == '0))
        else $error("idle with leftover sort state");

    // A held result stays put while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && order_stall) |=> out_valid_reg && $stable(out_item_reg))
        else $error("stalled result changed");

    // A new result is loaded only from an emit state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && order_stall))
            |-> (state_reg == ST_EMIT) || (state_reg == ST_NONE))
        else $error("result loaded outside emit");

endmodule

@@ rtl/kts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the Kahn topological sort block.
`timescale 1ns / 1ps

module tb_top;
    import kts_pkg::*;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          PHASE_COUNT   = 9;
    localparam int          PHASE_ITEMS   = 5;
    localparam int          OVERFLOW_LEN  = 260;

    typedef enum int unsigned {SHAPE_DAG, SHAPE_ANY, SHAPE_NOISE} graph_shape_e;

    // Predicts the vertex order of each graph and checks the block's order items
    class topo_order_scoreboard;
        logic [NODE_W-1:0] src_mem [MAX_EDGES];
        logic [NODE_W-1:0] dst_mem [MAX_EDGES];
        int unsigned       stored_edges;
        int unsigned       indegree [MAX_NODES];
        bit                any_dropped;
        int unsigned       node_count;
        order_item_t       pending_order [$];
        int unsigned       fail_cnt;
        int unsigned       graph_cnt;
        int unsigned       vertex_cnt;
        int unsigned       cyclic_cnt;
        int unsigned       dropped_cnt;

        function new();
            stored_edges = 0;
            any_dropped  = 1'b0;
            node_count   = 64;
            fail_cnt     = 0;
            graph_cnt    = 0;
            vertex_cnt   = 0;
            cyclic_cnt   = 0;
            dropped_cnt  = 0;
            foreach (indegree[i])
                indegree[i] = 0;
        endfunction

        function void set_node_count(logic [CFG_W-1:0] value);
            node_count = value;
        endfunction

        // Queue one expected order item at the back
        function void append_expected(order_item_t res);
            pending_order = {pending_order, res};
        endfunction

        // Load the edge, and on the final item order the graph
        function void note_edge_item(edge_item_t it);
            int unsigned span;
            int unsigned ready_q [$];
            int unsigned v;
            int unsigned emitted;
            order_item_t res;
            span = (node_count > MAX_NODES) ? MAX_NODES : node_count;
            if (it.carries_edge) begin
                if (it.edge_source >= span || it.edge_target >= span ||
                    stored_edges >= MAX_EDGES)
                    any_dropped = 1'b1;
                else begin
                    src_mem[stored_edges] = it.edge_source;
                    dst_mem[stored_edges] = it.edge_target;
                    stored_edges++;
                    indegree[it.edge_target]++;
                end
            end
            if (!it.final_item)
                return;

            // Seed with every source vertex in index order
            for (int i = 0; i < span; i++)
                if (indegree[i] == 0)
                    ready_q = {ready_q, int'(i)};

            // Emit vertices and release their successors
            emitted = 0;
            while (ready_q.size() != 0) begin
                v = ready_q.pop_front();
                res = '0;
                res.vertex       = NODE_W'(v);
                res.vertex_valid = 1'b1;
                append_expected(res);
                emitted++;
                for (int e = 0; e < stored_edges; e++) begin
                    if (src_mem[e] == v && indegree[dst_mem[e]] != 0) begin
                        indegree[dst_mem[e]]--;
                        if (indegree[dst_mem[e]] == 0)
                            ready_q = {ready_q, 32'(dst_mem[e])};
                    end
                end
            end

            // Flag the closing item, or stand in an invalid one for an empty order
            if (emitted == 0)
                res = '0;
            else
                res = pending_order.pop_back();
            res.last_of_run   = 1'b1;
            res.cycle_found   = (emitted < span);
            res.edges_dropped = any_dropped;
            append_expected(res);

            // Clear the graph for the next load
            stored_edges = 0;
            any_dropped  = 1'b0;
            foreach (indegree[i])
                indegree[i] = 0;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fail_cnt++;
            end
        endfunction

        function void check_order_item(order_item_t got);
            order_item_t want;
            if (pending_order.size() == 0) begin
                $error("unexpected order item: vertex %0d valid %0d last %0d",
                       got.vertex, got.vertex_valid, got.last_of_run);
                fail_cnt++;
                return;
            end
            want = pending_order.pop_front();
            compare_field("vertex",        want.vertex,        got.vertex);
            compare_field("vertex_valid",  want.vertex_valid,  got.vertex_valid);
            compare_field("last_of_run",   want.last_of_run,   got.last_of_run);
            compare_field("cycle_found",   want.cycle_found,   got.cycle_found);
            compare_field("edges_dropped", want.edges_dropped, got.edges_dropped);
            vertex_cnt += got.vertex_valid;
            if (got.last_of_run) begin
                graph_cnt++;
                cyclic_cnt  += got.cycle_found;
                dropped_cnt += got.edges_dropped;
            end
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             edge_valid  = 1'b0;
    logic             edge_stall;
    edge_item_t       edge_item   = '0;
    logic             order_valid;
    logic             order_stall = 1'b0;
    order_item_t      order_item;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data    = '0;

    topo_order_scoreboard sb;
    int unsigned          tx_idle_pct  = 28;
    int unsigned          rx_idle_pct  = 83;
    bit                   hold_request = 1'b0;
    int unsigned          item_total   = 0;
    int unsigned          cycle_cnt    = 0;

    kahn_topological_sort_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .edge_valid  (edge_valid),
        .edge_stall  (edge_stall),
        .edge_item   (edge_item),
        .order_valid (order_valid),
        .order_stall (order_stall),
        .order_item  (order_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // Free-running clock
    always
    begin
        clk = 1'b1;
        #(CLK_PERIOD / 2);
        clk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    // Check order items and drive the output stall, with one long hold-off on request
    initial
    begin : order_side
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && order_valid && !order_stall)
                sb.check_order_item(order_item);
            if (hold_left != 0) begin
                hold_left--;
                order_stall <= 1'b1;
            end else if (hold_request && order_valid) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                order_stall  <= 1'b1;
            end else
                order_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic edge_item_t mk_item(int unsigned src, int unsigned dst,
                                           bit has_edge, bit last);
        edge_item_t it;
        it.edge_source  = NODE_W'(src);
        it.edge_target  = NODE_W'(dst);
        it.carries_edge = has_edge;
        it.final_item   = last;
        return it;
    endfunction

    // Offer one edge item after a random gap and hold it until accepted
    task automatic send_item(edge_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            edge_valid <= 1'b0;
            @(posedge clk);
        end
        edge_valid <= 1'b1;
        edge_item  <= it;
        do
            @(posedge clk);
        while (edge_stall);
        sb.note_edge_item(it);
        item_total++;
    endtask

    // Send len + 1 items of the given shape, the last one marked final
    task automatic send_graph(int unsigned span, int unsigned len, graph_shape_e shape);
        int unsigned a;
        int unsigned b;
        int unsigned t;
        bit          has_edge;
        for (int unsigned k = 0; k <= len; k++) begin
            a        = $urandom_range(span - 1);
            b        = $urandom_range(span - 1);
            has_edge = ($urandom_range(99) >= 8);
            case (shape)
                SHAPE_DAG:
                begin
                    if (a > b) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                SHAPE_NOISE:
                begin
                    a        = $urandom_range(63);
                    b        = $urandom_range(63);
                    has_edge = 1'($urandom_range(1));
                end
                default:
                begin
                end
            endcase
            send_item(mk_item(a, b, has_edge, k == len));
        end
    endtask

    // Let every expected order item arrive, then let the block settle
    task automatic wait_drained();
        edge_valid <= 1'b0;
        while (sb.pending_order.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_node_count(value);
    endtask

    // Main sequence: directed graphs, then random phases over several node counts
    initial
    begin : stimulus
        int unsigned  phase_nodes [PHASE_COUNT];
        int unsigned  span;
        int unsigned  len;
        int unsigned  phase_items;
        int unsigned  pick;
        int unsigned  ov_src;
        int unsigned  ov_dst;
        graph_shape_e shape;

        phase_nodes = '{8, 64, 127, 3, 40, 0, 16, 64, 1};
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset node count: empty graph, then a two-vertex cycle
        send_item(mk_item(0, 0, 1'b0, 1'b1));
        send_item(mk_item(63, 0, 1'b1, 1'b0));
        send_item(mk_item(0, 63, 1'b1, 1'b0));
        send_item(mk_item(5, 6, 1'b1, 1'b1));

        // Three vertices: full cycle with an out-of-range edge, then a small DAG
        write_node_count(CFG_W'(3));
        send_item(mk_item(0, 1, 1'b1, 1'b0));
        send_item(mk_item(1, 2, 1'b1, 1'b0));
        send_item(mk_item(3, 0, 1'b1, 1'b0));
        send_item(mk_item(2, 0, 1'b1, 1'b1));
        send_item(mk_item(0, 2, 1'b1, 1'b0));
        send_item(mk_item(0, 1, 1'b0, 1'b0));
        send_item(mk_item(1, 2, 1'b1, 1'b1));

        // No vertices: every edge dropped, empty order
        write_node_count(CFG_W'(0));
        send_item(mk_item(0, 0, 1'b1, 1'b1));
        send_item(mk_item(0, 0, 1'b0, 1'b1));

        // Count above capacity clamps to the full vertex range
        write_node_count(CFG_W'(127));
        send_item(mk_item(63, 62, 1'b1, 1'b1));

        // One vertex: self loop, then an out-of-range edge
        write_node_count(CFG_W'(1));
        send_item(mk_item(0, 0, 1'b1, 1'b1));
        send_item(mk_item(0, 1, 1'b1, 1'b1));

        // Repeated edges raise an in-degree above one
        write_node_count(CFG_W'(64));
        send_item(mk_item(2, 1, 1'b1, 1'b0));
        send_item(mk_item(2, 1, 1'b1, 1'b0));
        send_item(mk_item(1, 0, 1'b1, 1'b1));

        // Random phases: mostly well-formed graphs, some cyclic ones and noise
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p < 3) begin
                tx_idle_pct = 28;
                rx_idle_pct = 83;
            end else if (p < 6) begin
                tx_idle_pct = 83;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_node_count(CFG_W'(phase_nodes[p]));
            span = (phase_nodes[p] == 0) ? MAX_NODES :
                   (phase_nodes[p] > MAX_NODES) ? MAX_NODES : phase_nodes[p];
            if (p == 6) begin
                // Hold the output while the next graph keeps pushing items
                hold_request = 1'b1;
                send_graph(span, 4, SHAPE_DAG);
                send_graph(span, 4, SHAPE_DAG);
            end
            if (p == 7) begin
                // Fill the edge store past capacity with an acyclic graph
                for (int k = 0; k <= OVERFLOW_LEN; k++) begin
                    ov_src = $urandom_range(MAX_NODES - 2);
                    ov_dst = $urandom_range(MAX_NODES - 1, ov_src + 1);
                    send_item(mk_item(ov_src, ov_dst, 1'b1, k == OVERFLOW_LEN));
                end
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick  = $urandom_range(99);
                shape = (pick < 60) ? SHAPE_DAG : (pick < 80) ? SHAPE_ANY : SHAPE_NOISE;
                len   = ($urandom_range(7) == 0 && span >= 8) ? $urandom_range(40)
                                                               : $urandom_range(10);
                send_graph(span, len, shape);
                phase_items += len + 1;
            end
        end

        wait_drained();
        if (sb.pending_order.size() != 0) begin
            $error("%0d order items never arrived", sb.pending_order.size());
            sb.fail_cnt++;
        end
        $display("sent %0d edge items over %0d node-count settings", item_total,
                 PHASE_COUNT + 6);
        $display("checked %0d sorted graphs, %0d vertices, %0d with cycles, %0d with drops",
                 sb.graph_cnt, sb.vertex_cnt, sb.cyclic_cnt, sb.dropped_cnt);
        if (sb.fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/kahn_topological_sort_top.sv
dv/tb_top.sv
